FILE: sv/normalized_sample_window_buffer_core_macros.svh
// assertion macros shared by the checker of the window buffer core
// depends on nothing; taken in by `include
`ifndef NORMALIZED_SAMPLE_WINDOW_BUFFER_CORE_MACROS_SVH
`define NORMALIZED_SAMPLE_WINDOW_BUFFER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define NSWB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("window buffer check failed");

// next-cycle implication, disabled while reset is low
`define NSWB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("window buffer check failed");

`endif

FILE: sv/nswb_pkg.sv
// shared types and constants of the normalized sample window buffer
// used by the front, queue, back and top level; depends on nothing
package nswb_pkg;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    typedef enum logic [2:0] {
        CFG_MEAN_X    = 3'd0,
        CFG_MEAN_Y    = 3'd1,
        CFG_MEAN_Z    = 3'd2,
        CFG_RECIP_X   = 3'd3,
        CFG_RECIP_Y   = 3'd4,
        CFG_RECIP_Z   = 3'd5,
        CFG_WINDOW    = 3'd6,
        CFG_WARMUP    = 3'd7
    } t_cfg_idx;

    localparam logic [15:0] RST_MEAN_X  = 16'hFFEB;
    localparam logic [15:0] RST_MEAN_Y  = 16'hFFB9;
    localparam logic [15:0] RST_MEAN_Z  = 16'd4050;
    localparam logic [15:0] RST_RECIP_X = 16'd19832;
    localparam logic [15:0] RST_RECIP_Y = 16'd30971;
    localparam logic [15:0] RST_RECIP_Z = 16'd27660;
    localparam logic [7:0]  RST_WINDOW  = 8'd125;
    localparam logic [9:0]  RST_WARMUP  = 10'd125;

    localparam int unsigned WINDOW_MAX  = 128;
    localparam logic [9:0]  SEEN_MAX    = 10'd1023;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;

    typedef struct packed {
        logic signed [15:0] mean_x;
        logic signed [15:0] mean_y;
        logic signed [15:0] mean_z;
        logic [15:0]        recip_x;
        logic [15:0]        recip_y;
        logic [15:0]        recip_z;
    } t_norm_cfg;

    typedef struct packed {
        logic [7:0] window;
        logic [9:0] warmup;
    } t_back_cfg;

    // one classified item: mode plus the normalized entry for a sample
    typedef struct packed {
        logic               mode;
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    typedef struct packed {
        logic               window_ready;
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] first_z;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
        logic signed [15:0] second_z;
        logic               second_valid;
        logic               last_of_run;
    } t_result;

endpackage

FILE: sv/nswb_front.sv
// front part: accepts input items, normalizes samples to q8.8
// depends on nswb_pkg
module nswb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_mode,
    input  logic signed [15:0]  i_accel_x,
    input  logic signed [15:0]  i_accel_y,
    input  logic signed [15:0]  i_accel_z,
    input  nswb_pkg::t_norm_cfg i_cfg,
    input  logic                i_full,
    output nswb_pkg::t_push     o_push
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_DIFF = 4'b0010,
        F_MUL  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate r_state, n_state;

    logic               r_mode;
    logic signed [15:0] r_acc  [3];
    logic signed [16:0] r_diff [3];
    logic signed [33:0] r_prod [3];

    logic signed [15:0] means  [3];
    logic signed [16:0] recips [3];
    logic signed [15:0] norm   [3];
    logic               accept;

    assign means[0]  = i_cfg.mean_x;
    assign means[1]  = i_cfg.mean_y;
    assign means[2]  = i_cfg.mean_z;
    assign recips[0] = $signed({1'b0, i_cfg.recip_x});
    assign recips[1] = $signed({1'b0, i_cfg.recip_y});
    assign recips[2] = $signed({1'b0, i_cfg.recip_z});

    assign o_in_stall = (r_state != F_IDLE);
    assign accept     = i_in_valid && (r_state == F_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = (i_mode == nswb_pkg::MODE_READ) ? F_PUSH : F_DIFF;
                end
            end
            F_DIFF: n_state = F_MUL;
            F_MUL:  n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_acc[0] <= i_accel_x;
            r_acc[1] <= i_accel_y;
            r_acc[2] <= i_accel_z;
        end
        for (int k = 0; k < 3; k++) begin
            if (r_state == F_DIFF) begin
                r_diff[k] <= 17'(r_acc[k]) - 17'(means[k]);
            end
            if (r_state == F_MUL) begin
                r_prod[k] <= r_diff[k] * recips[k];
            end
        end
    end

    // round half up to 8 fraction bits, then saturate
    always_comb begin
        logic signed [33:0] sum;
        logic signed [33:0] q;
        for (int k = 0; k < 3; k++) begin
            sum = r_prod[k] + 34'sd16384;
            q   = sum >>> 15;
            if (q > 34'sd32767) begin
                norm[k] = 16'sh7FFF;
            end else if (q < -34'sd32768) begin
                norm[k] = 16'sh8000;
            end else begin
                norm[k] = q[15:0];
            end
        end
    end

    assign o_push.valid   = (r_state == F_PUSH);
    assign o_push.cmd.mode = r_mode;
    assign o_push.cmd.x   = norm[0];
    assign o_push.cmd.y   = norm[1];
    assign o_push.cmd.z   = norm[2];

endmodule

FILE: sv/nswb_queue.sv
// short queue of classified items between front and back
// depends on nswb_pkg
module nswb_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  nswb_pkg::t_push       i_push,
    input  logic                  i_pop,
    output nswb_pkg::t_cmd        o_cmd,
    output nswb_pkg::t_queue_stat o_stat
);

    localparam int unsigned AW = nswb_pkg::QUEUE_AW;

    nswb_pkg::t_cmd r_slot [nswb_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [AW:0]    r_count;
    logic           do_push, do_pop;

    assign o_stat.full  = (r_count == (AW+1)'(nswb_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push.valid && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_push.cmd;
        end
    end

endmodule

FILE: sv/nswb_back.sv
// back part: sample ring buffer, warm-up tracking and window streaming
// depends on nswb_pkg
module nswb_back #(
    parameter int unsigned BUFFER_SAMPLES = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  nswb_pkg::t_back_cfg   i_cfg,
    input  nswb_pkg::t_cmd        i_cmd,
    input  nswb_pkg::t_queue_stat i_stat,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output nswb_pkg::t_result     o_result
);

    localparam int unsigned AW     = $clog2(BUFFER_SAMPLES);
    localparam logic [AW:0] BufLen = (AW+1)'(BUFFER_SAMPLES);
    localparam logic [AW-1:0] LastIdx = AW'(BUFFER_SAMPLES - 1);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_FETCH = 3'b010,
        B_LOAD  = 3'b100
    } t_bstate;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == LastIdx) ? '0 : p + 1'b1;
    endfunction

    t_bstate r_state, n_state;

    logic [47:0]   r_mem [BUFFER_SAMPLES];
    logic [AW-1:0] r_wp;
    logic          r_wrapped;
    logic [9:0]    r_seen;
    logic          r_warm;
    logic          r_fresh;

    logic [AW-1:0] r_ptr;
    logic [7:0]    r_left;
    logic [47:0]   r_rd_a, r_rd_b;
    logic          r_ok_a, r_ok_b;

    logic              r_out_valid;
    nswb_pkg::t_result r_out, n_out;

    logic          out_free;
    logic          pop_sample, pop_read;
    logic          warm_next, ready;
    logic [7:0]    win_n;
    logic [AW-1:0] oldest, ptr_b;
    logic          load_out;
    logic [47:0]   smp_a, smp_b;
    logic          pair;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign pop_sample = (r_state == B_IDLE) && !i_stat.empty
                        && (i_cmd.mode == nswb_pkg::MODE_SAMPLE);
    assign pop_read   = (r_state == B_IDLE) && !i_stat.empty
                        && (i_cmd.mode == nswb_pkg::MODE_READ) && out_free;
    assign o_pop      = pop_sample || pop_read;

    assign warm_next = r_warm || (r_fresh && (r_seen >= i_cfg.warmup));
    assign ready     = r_fresh && warm_next;

    // window length clamped to one through the window maximum
    always_comb begin
        if (i_cfg.window == '0) begin
            win_n = 8'd1;
        end else if (i_cfg.window > 8'(nswb_pkg::WINDOW_MAX)) begin
            win_n = 8'(nswb_pkg::WINDOW_MAX);
        end else begin
            win_n = i_cfg.window;
        end
    end

    // oldest window entry, wrapping at the buffer length
    assign oldest = ({1'b0, r_wp} >= (AW+1)'(win_n))
                    ? AW'({1'b0, r_wp} - (AW+1)'(win_n))
                    : AW'(({1'b0, r_wp} + BufLen) - (AW+1)'(win_n));
    assign ptr_b  = wrap_inc(r_ptr);
    assign pair   = (r_left >= 8'd2);

    assign smp_a    = r_ok_a ? r_rd_a : '0;
    assign smp_b    = (pair && r_ok_b) ? r_rd_b : '0;
    assign load_out = (pop_read && !ready) || ((r_state == B_LOAD) && out_free);

    always_comb begin
        n_out = '0;
        if (r_state == B_LOAD) begin
            n_out.window_ready = 1'b1;
            n_out.first_x      = smp_a[15:0];
            n_out.first_y      = smp_a[31:16];
            n_out.first_z      = smp_a[47:32];
            n_out.second_x     = smp_b[15:0];
            n_out.second_y     = smp_b[31:16];
            n_out.second_z     = smp_b[47:32];
            n_out.second_valid = pair;
            n_out.last_of_run  = (r_left <= 8'd2);
        end else begin
            // not ready: single result with only the last flag set
            n_out.last_of_run  = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (pop_read && ready) begin
                    n_state = B_FETCH;
                end
            end
            B_FETCH: n_state = B_LOAD;
            B_LOAD: begin
                if (out_free) begin
                    n_state = (r_left <= 8'd2) ? B_IDLE : B_FETCH;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_seen      <= '0;
            r_warm      <= 1'b0;
            r_fresh     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop_sample) begin
                r_wp    <= wrap_inc(r_wp);
                r_fresh <= 1'b1;
                if (r_wp == LastIdx) begin
                    r_wrapped <= 1'b1;
                end
                if (r_seen != nswb_pkg::SEEN_MAX) begin
                    r_seen <= r_seen + 1'b1;
                end
            end
            if (pop_read) begin
                r_fresh <= 1'b0;
                r_warm  <= warm_next;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // entries past the fill point before the first wrap read as zero
    always_ff @(posedge i_clk) begin
        if (pop_sample) begin
            r_mem[r_wp] <= {i_cmd.z, i_cmd.y, i_cmd.x};
        end
        r_rd_a <= r_mem[r_ptr];
        r_rd_b <= r_mem[ptr_b];
        r_ok_a <= r_wrapped || (r_ptr < r_wp);
        r_ok_b <= r_wrapped || (ptr_b < r_wp);
        if (pop_read) begin
            r_ptr  <= oldest;
            r_left <= win_n;
        end else if ((r_state == B_LOAD) && out_free) begin
            r_ptr  <= wrap_inc(ptr_b);
            r_left <= r_left - 8'd2;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

FILE: sv/normalized_sample_window_buffer_core.sv
// sample item: passes the front in steps (subtract, multiply, round and queue), no result
// read item: goes straight to the queue; once popped, a not-ready read loads its lone result
// on the pop, a ready one streams results, each by a buffer read, then an output load;
// the front takes no new item until it is done with the last; a 4-deep queue lets samples
// enter during streaming; synchronous active-low reset clears control state and loads
// register defaults; no clearing pass: unwritten entries read as zero through fill tracking
module normalized_sample_window_buffer_core #(
    parameter int unsigned BUFFER_SAMPLES = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_window_ready,
    output logic signed [15:0] o_first_x,
    output logic signed [15:0] o_first_y,
    output logic signed [15:0] o_first_z,
    output logic signed [15:0] o_second_x,
    output logic signed [15:0] o_second_y,
    output logic signed [15:0] o_second_z,
    output logic               o_second_valid,
    output logic               o_last_of_run,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);

    nswb_pkg::t_norm_cfg   r_norm_cfg;
    nswb_pkg::t_back_cfg   r_back_cfg;
    nswb_pkg::t_push       push;
    nswb_pkg::t_cmd        cmd;
    nswb_pkg::t_queue_stat qstat;
    nswb_pkg::t_result     result;
    logic                  pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_cfg.mean_x  <= nswb_pkg::RST_MEAN_X;
            r_norm_cfg.mean_y  <= nswb_pkg::RST_MEAN_Y;
            r_norm_cfg.mean_z  <= nswb_pkg::RST_MEAN_Z;
            r_norm_cfg.recip_x <= nswb_pkg::RST_RECIP_X;
            r_norm_cfg.recip_y <= nswb_pkg::RST_RECIP_Y;
            r_norm_cfg.recip_z <= nswb_pkg::RST_RECIP_Z;
            r_back_cfg.window  <= nswb_pkg::RST_WINDOW;
            r_back_cfg.warmup  <= nswb_pkg::RST_WARMUP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nswb_pkg::CFG_MEAN_X:  r_norm_cfg.mean_x  <= i_cfg_data;
                nswb_pkg::CFG_MEAN_Y:  r_norm_cfg.mean_y  <= i_cfg_data;
                nswb_pkg::CFG_MEAN_Z:  r_norm_cfg.mean_z  <= i_cfg_data;
                nswb_pkg::CFG_RECIP_X: r_norm_cfg.recip_x <= i_cfg_data;
                nswb_pkg::CFG_RECIP_Y: r_norm_cfg.recip_y <= i_cfg_data;
                nswb_pkg::CFG_RECIP_Z: r_norm_cfg.recip_z <= i_cfg_data;
                nswb_pkg::CFG_WINDOW:  r_back_cfg.window  <= i_cfg_data[7:0];
                nswb_pkg::CFG_WARMUP:  r_back_cfg.warmup  <= i_cfg_data[9:0];
                default:               r_back_cfg         <= r_back_cfg;
            endcase
        end
    end

    nswb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_mode     (i_mode),
        .i_accel_x  (i_accel_x),
        .i_accel_y  (i_accel_y),
        .i_accel_z  (i_accel_z),
        .i_cfg      (r_norm_cfg),
        .i_full     (qstat.full),
        .o_push     (push)
    );

    nswb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_cmd   (cmd),
        .o_stat  (qstat)
    );

    nswb_back #(
        .BUFFER_SAMPLES (BUFFER_SAMPLES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_back_cfg),
        .i_cmd       (cmd),
        .i_stat      (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_window_ready = result.window_ready;
    assign o_first_x      = result.first_x;
    assign o_first_y      = result.first_y;
    assign o_first_z      = result.first_z;
    assign o_second_x     = result.second_x;
    assign o_second_y     = result.second_y;
    assign o_second_z     = result.second_z;
    assign o_second_valid = result.second_valid;
    assign o_last_of_run  = result.last_of_run;

endmodule

FILE: sv/nswb_checker.sv
// port-level checks of the window buffer core, bound to the top level
// depends on normalized_sample_window_buffer_core_macros.svh
`include "normalized_sample_window_buffer_core_macros.svh"

module nswb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_window_ready,
    input logic signed [15:0] o_first_x,
    input logic signed [15:0] o_first_y,
    input logic signed [15:0] o_first_z,
    input logic signed [15:0] o_second_x,
    input logic signed [15:0] o_second_y,
    input logic signed [15:0] o_second_z,
    input logic               o_second_valid,
    input logic               o_last_of_run
);

    // a stalled result holds
    `NSWB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_first_x) && $stable(o_second_z) && $stable(o_last_of_run))

    // not-ready result is a lone zero result that ends the run
    `NSWB_ASSERT_NOW(a_not_ready, i_clk, i_rst_n, o_out_valid && !o_window_ready, o_last_of_run && !o_second_valid && o_first_x == 16'sd0 && o_first_y == 16'sd0 && o_first_z == 16'sd0)

    // unpaired sample leaves the second slot zero
    `NSWB_ASSERT_NOW(a_unpaired_zero, i_clk, i_rst_n, o_out_valid && !o_second_valid, o_second_x == 16'sd0 && o_second_y == 16'sd0 && o_second_z == 16'sd0)

    // only the final result of a window may be unpaired
    `NSWB_ASSERT_NOW(a_pairs_inside, i_clk, i_rst_n, o_out_valid && o_window_ready && !o_last_of_run, o_second_valid)

endmodule

bind normalized_sample_window_buffer_core nswb_checker u_nswb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_window_ready (o_window_ready),
    .o_first_x      (o_first_x),
    .o_first_y      (o_first_y),
    .o_first_z      (o_first_z),
    .o_second_x     (o_second_x),
    .o_second_y     (o_second_y),
    .o_second_z     (o_second_z),
    .o_second_valid (o_second_valid),
    .o_last_of_run  (o_last_of_run)
);

FILE: bench/nswb_window_checker.sv
// result checker for the window buffer core: keeps its own copy of the buffer,
// predicts every read and compares the output channel; depends on nswb_pkg
module nswb_window_checker
    import nswb_pkg::*;
#(
    parameter int unsigned BUFFER_SAMPLES = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_mode,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_result            i_result,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output int                 o_mismatches,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [47:0] norm_store [BUFFER_SAMPLES];
    int unsigned wr_ptr;
    logic [9:0]  seen_count;
    logic        warmed;
    logic        fresh;
    t_norm_cfg   norm_cfg;
    logic [7:0]  window_cfg;
    logic [9:0]  warmup_cfg;
    t_result     window_due [$];
    int          mismatch_total = 0;
    int          due_count = 0;

    assign o_mismatches = mismatch_total;
    assign o_pending    = due_count;

    // (accel - mean) * recip in Q5.11 x Q4.12, rounded half up to Q8.8 and saturated
    function automatic logic [15:0] scale_axis_q88(input logic signed [15:0] accel,
                                                   input logic signed [15:0] mean,
                                                   input logic [15:0] recip);
        longint prod;
        longint q;
        prod = (longint'(accel) - longint'(mean)) * longint'(recip) + 64'sd16384;
        q = prod >>> 15;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    always @(posedge i_clk) begin : watch
        t_result     expd;
        t_result     res;
        logic        was_fresh;
        int unsigned n;
        int unsigned oldest;
        int unsigned pairs;
        logic [47:0] ea;
        logic [47:0] eb;
        if (!i_rst_n) begin
            foreach (norm_store[k]) norm_store[k] = '0;
            wr_ptr     = 0;
            seen_count = '0;
            warmed     = 1'b0;
            fresh      = 1'b0;
            norm_cfg   = '{RST_MEAN_X, RST_MEAN_Y, RST_MEAN_Z,
                           RST_RECIP_X, RST_RECIP_Y, RST_RECIP_Z};
            window_cfg = RST_WINDOW;
            warmup_cfg = RST_WARMUP;
            window_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MEAN_X:  norm_cfg.mean_x  = i_cfg_data;
                    CFG_MEAN_Y:  norm_cfg.mean_y  = i_cfg_data;
                    CFG_MEAN_Z:  norm_cfg.mean_z  = i_cfg_data;
                    CFG_RECIP_X: norm_cfg.recip_x = i_cfg_data;
                    CFG_RECIP_Y: norm_cfg.recip_y = i_cfg_data;
                    CFG_RECIP_Z: norm_cfg.recip_z = i_cfg_data;
                    CFG_WINDOW:  window_cfg = i_cfg_data[7:0];
                    CFG_WARMUP:  warmup_cfg = i_cfg_data[9:0];
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                if (window_due.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display("%0t: result transfer with nothing expected", $time);
                end else begin
                    expd = window_due.pop_front();
                    if (i_result.window_ready !== expd.window_ready ||
                        i_result.first_x !== expd.first_x ||
                        i_result.first_y !== expd.first_y ||
                        i_result.first_z !== expd.first_z ||
                        i_result.second_x !== expd.second_x ||
                        i_result.second_y !== expd.second_y ||
                        i_result.second_z !== expd.second_z ||
                        i_result.second_valid !== expd.second_valid ||
                        i_result.last_of_run !== expd.last_of_run) begin
                        mismatch_total++;
                        if (mismatch_total <= 10) begin
                            $display("%0t: window result mismatch", $time);
                            $display("  expected rdy=%0b (%0d %0d %0d) (%0d %0d %0d) sv=%0b last=%0b",
                                     expd.window_ready, expd.first_x, expd.first_y,
                                     expd.first_z, expd.second_x, expd.second_y,
                                     expd.second_z, expd.second_valid, expd.last_of_run);
                            $display("  actual   rdy=%0b (%0d %0d %0d) (%0d %0d %0d) sv=%0b last=%0b",
                                     i_result.window_ready, i_result.first_x,
                                     i_result.first_y, i_result.first_z, i_result.second_x,
                                     i_result.second_y, i_result.second_z,
                                     i_result.second_valid, i_result.last_of_run);
                        end
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                if (i_mode == MODE_SAMPLE) begin
                    norm_store[wr_ptr] = {
                        scale_axis_q88(i_accel_z, norm_cfg.mean_z, norm_cfg.recip_z),
                        scale_axis_q88(i_accel_y, norm_cfg.mean_y, norm_cfg.recip_y),
                        scale_axis_q88(i_accel_x, norm_cfg.mean_x, norm_cfg.recip_x)};
                    wr_ptr = (wr_ptr + 1) % BUFFER_SAMPLES;
                    if (seen_count != SEEN_MAX) seen_count++;
                    fresh = 1'b1;
                end else begin
                    was_fresh = fresh;
                    fresh = 1'b0;
                    // warm-up flag is sticky until reset
                    if (was_fresh && seen_count >= warmup_cfg) warmed = 1'b1;
                    if (!was_fresh || !warmed) begin
                        res = '0;
                        res.last_of_run = 1'b1;
                        window_due.push_back(res);
                    end else begin
                        n = window_cfg;
                        if (n == 0) n = 1;
                        if (n > WINDOW_MAX) n = WINDOW_MAX;
                        oldest = (wr_ptr + BUFFER_SAMPLES - n) % BUFFER_SAMPLES;
                        pairs = (n + 1) / 2;
                        for (int unsigned k = 0; k < pairs; k++) begin
                            ea = norm_store[(oldest + 2 * k) % BUFFER_SAMPLES];
                            res = '0;
                            res.window_ready = 1'b1;
                            res.first_x = ea[15:0];
                            res.first_y = ea[31:16];
                            res.first_z = ea[47:32];
                            // odd window leaves the last sample unpaired
                            if (2 * k + 1 < n) begin
                                eb = norm_store[(oldest + 2 * k + 1) % BUFFER_SAMPLES];
                                res.second_x = eb[15:0];
                                res.second_y = eb[31:16];
                                res.second_z = eb[47:32];
                                res.second_valid = 1'b1;
                            end
                            res.last_of_run = (k + 1 == pairs);
                            window_due.push_back(res);
                        end
                    end
                end
            end
        end
        due_count = window_due.size();
    end

endmodule

FILE: bench/testbench.sv
// top of the window buffer core testbench: clock, reset, stimulus and verdict
// depends on nswb_pkg, the core and nswb_window_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import nswb_pkg::*;

    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               i_mode = MODE_SAMPLE;
    logic signed [15:0] i_accel_x = '0;
    logic signed [15:0] i_accel_y = '0;
    logic signed [15:0] i_accel_z = '0;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = CFG_MEAN_X;
    logic [15:0]        i_cfg_data = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_window_ready;
    logic signed [15:0] o_first_x;
    logic signed [15:0] o_first_y;
    logic signed [15:0] o_first_z;
    logic signed [15:0] o_second_x;
    logic signed [15:0] o_second_y;
    logic signed [15:0] o_second_z;
    logic               o_second_valid;
    logic               o_last_of_run;

    t_result     dut_result;
    int          mismatches;
    int          pending;
    int          cycle_count = 0;
    logic        steady_run = 1'b0;
    logic [15:0] cur_mean [3];

    always #5 i_clk = ~i_clk;

    normalized_sample_window_buffer_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_window_ready (o_window_ready),
        .o_first_x      (o_first_x),
        .o_first_y      (o_first_y),
        .o_first_z      (o_first_z),
        .o_second_x     (o_second_x),
        .o_second_y     (o_second_y),
        .o_second_z     (o_second_z),
        .o_second_valid (o_second_valid),
        .o_last_of_run  (o_last_of_run),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    assign dut_result = {o_window_ready, o_first_x, o_first_y, o_first_z,
                         o_second_x, o_second_y, o_second_z, o_second_valid, o_last_of_run};

    nswb_window_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_result     (dut_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always @(negedge i_clk) begin
        i_out_stall <= !steady_run && ($urandom_range(0, 99) < 31);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL normalized_sample_window_buffer_core");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input logic mode, input logic [15:0] ax,
                             input logic [15:0] ay, input logic [15:0] az);
        if (!steady_run && $urandom_range(0, 99) < 31) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_accel_x  <= ax;
        i_accel_y  <= ay;
        i_accel_z  <= az;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // drain all results, then give the front end time to finish any samples
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_config(input logic [15:0] mx, input logic [15:0] my,
                               input logic [15:0] mz, input logic [15:0] rx,
                               input logic [15:0] ry, input logic [15:0] rz,
                               input logic [15:0] win, input logic [15:0] warm);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_MEAN_X;  i_cfg_data <= mx;   @(negedge i_clk);
        i_cfg_idx <= CFG_MEAN_Y;  i_cfg_data <= my;   @(negedge i_clk);
        i_cfg_idx <= CFG_MEAN_Z;  i_cfg_data <= mz;   @(negedge i_clk);
        i_cfg_idx <= CFG_RECIP_X; i_cfg_data <= rx;   @(negedge i_clk);
        i_cfg_idx <= CFG_RECIP_Y; i_cfg_data <= ry;   @(negedge i_clk);
        i_cfg_idx <= CFG_RECIP_Z; i_cfg_data <= rz;   @(negedge i_clk);
        i_cfg_idx <= CFG_WINDOW;  i_cfg_data <= win;  @(negedge i_clk);
        i_cfg_idx <= CFG_WARMUP;  i_cfg_data <= warm; @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mean[0] = mx;
        cur_mean[1] = my;
        cur_mean[2] = mz;
    endtask

    // half full-range values, half close to the mean so outputs stay unsaturated
    function automatic logic [15:0] rand_axis(input logic [15:0] mean);
        logic [15:0] offset;
        offset = 16'($urandom_range(0, 4095));
        if ($urandom_range(0, 1)) return 16'($urandom);
        return mean + offset - 16'd2048;
    endfunction

    function automatic logic [15:0] pick_mean();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom_range(0, 8191)) - 16'd4096;
        endcase
    endfunction

    function automatic logic [15:0] pick_recip();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 32767));
        endcase
    endfunction

    initial begin : stimulus
        int          sent;
        int          run_len;
        logic [15:0] win;
        cur_mean[0] = RST_MEAN_X;
        cur_mean[1] = RST_MEAN_Y;
        cur_mean[2] = RST_MEAN_Z;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // nothing fresh, then fresh but short of the default warm-up
        send_item(MODE_READ, 16'h0000, 16'h0000, 16'h0000);
        send_item(MODE_SAMPLE, 16'h7FFF, 16'h8000, 16'h0000);
        send_item(MODE_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // full-scale saturation both ways, zero scale on z, warm-up of zero
        load_config(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                    16'd5, 16'd0);
        send_item(MODE_SAMPLE, 16'h7FFF, 16'h8000, 16'h3039);
        // window longer than history pulls in unwritten entries, which read as zero
        send_item(MODE_READ, 16'h0000, 16'h0000, 16'h0000);
        send_item(MODE_READ, 16'h0000, 16'h0000, 16'h0000);
        send_item(MODE_SAMPLE, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_item(MODE_READ, 16'h0000, 16'h0000, 16'h0000);

        // rounding at exactly one half, both signs; window zero acts as one,
        // warm-up raised above the sample count must not undo warm state
        load_config(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h1000, 16'h8000,
                    16'd0, 16'h03FF);
        send_item(MODE_SAMPLE, 16'h4000, 16'h0008, 16'h0001);
        send_item(MODE_SAMPLE, 16'hC000, 16'hFFFC, 16'hFFFF);
        send_item(MODE_SAMPLE, 16'hBFFF, 16'hFFF8, 16'h8000);
        send_item(MODE_READ, 16'h0000, 16'h0000, 16'h0000);

        // window register above the maximum clamps to the largest window
        load_config(RST_MEAN_X, RST_MEAN_Y, RST_MEAN_Z, RST_RECIP_X, RST_RECIP_Y,
                    RST_RECIP_Z, 16'hFFFF, 16'd1);
        send_item(MODE_SAMPLE, rand_axis(cur_mean[0]), rand_axis(cur_mean[1]),
                  rand_axis(cur_mean[2]));
        send_item(MODE_READ, 16'h0000, 16'h0000, 16'h0000);

        // odd window: last result of the run carries one sample
        load_config(RST_MEAN_X, RST_MEAN_Y, RST_MEAN_Z, RST_RECIP_X, RST_RECIP_Y,
                    RST_RECIP_Z, 16'd7, 16'd1);
        repeat (4) send_item(MODE_SAMPLE, rand_axis(cur_mean[0]), rand_axis(cur_mean[1]),
                             rand_axis(cur_mean[2]));
        send_item(MODE_READ, 16'h0000, 16'h0000, 16'h0000);
        send_item(MODE_READ, 16'h0000, 16'h0000, 16'h0000);
        send_item(MODE_SAMPLE, rand_axis(cur_mean[0]), rand_axis(cur_mean[1]),
                  rand_axis(cur_mean[2]));
        send_item(MODE_READ, 16'h0000, 16'h0000, 16'h0000);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1: win = 16'd128;
                4: win = 16'($urandom_range(129, 255));
                default: win = 16'($urandom_range(1, 16));
            endcase
            load_config(pick_mean(), pick_mean(), pick_mean(), pick_recip(), pick_recip(),
                        pick_recip(), win, 16'($urandom_range(1, 512)));
            steady_run = (phase == 2 || phase == 3);
            sent = 0;
            while (sent < 15) begin
                if ($urandom_range(0, 99) < 80) begin
                    run_len = $urandom_range(1, 6);
                    repeat (run_len) send_item(MODE_SAMPLE, rand_axis(cur_mean[0]),
                                               rand_axis(cur_mean[1]),
                                               rand_axis(cur_mean[2]));
                    send_item(MODE_READ, 16'($urandom), 16'($urandom), 16'($urandom));
                    sent += run_len + 1;
                end else begin
                    // stray item: lone read or sample with raw fields
                    send_item(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                              16'($urandom));
                    sent++;
                end
            end
        end
        steady_run = 1'b0;

        settle();
        if (mismatches == 0)
            $display("PASS normalized_sample_window_buffer_core");
        else
            $display("FAIL normalized_sample_window_buffer_core");
        $finish;
    end

endmodule
